// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the frame buffer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdf_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package pdf_pkg;

    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int PAGES       = ROWS / 8;
    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    localparam logic [7:0] BYTE_DARK = 8'h00;
    localparam logic [7:0] BYTE_LIT  = 8'hFF;

    typedef enum logic [2:0] {
        REQ_PIXEL = 3'd0,
        REQ_RECT  = 3'd1,
        REQ_FILL  = 3'd2,
        REQ_CMP   = 3'd3,
        REQ_INVAL = 3'd4,
        REQ_READ  = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_RECT_RD,
        ST_RECT_WR,
        ST_CMP,
        ST_CMP_TAIL,
        ST_READ,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MASK,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic       pixel_on;
        logic [7:0] first_page;
        logic [7:0] last_page;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } req_fields_t;

    typedef struct packed {
        logic     load;
        logic     fill_wr;
        logic     fill_zero;
        logic     rmw_wr;
        logic     cmp_rd;
        logic     set_valid;
        logic     clr_valid;
        logic     finish;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic rect_empty;
        logic range_bad;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/page_diff_framebuffer.sv =====
// ----------------------------------------------------------------------------
// page_diff_framebuffer
// page-organized monochrome frame store with a shadow of the last sent image
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass (one frame store byte per cycle)
// before it takes the first request. One request is worked at a time: a
// pixel or rectangle reads and rewrites each touched byte, a screen fill
// writes every byte, and a compare sweeps the pages in its range (the whole
// store while the shadow is invalid). The work is paced by the frame store's
// single write port and the read-modify-write of each byte.
// A finished result sits in an output register, so the next request can be
// taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module page_diff_framebuffer (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, rect_width, rect_height, pixel_on, first_page,
    // last_page, read_page, read_column, zero pad
    input  wire  [pdf_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  wire  [pdf_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // pushed_mask, any_pushed, read_data, zero pad
    output logic [pdf_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pdf_pkg::*;

    `include "assert_macros.svh"

    req_fields_t req;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [7:0]  pushed_mask, read_data;
    logic        any_pushed;

    always_comb begin
        req.req_type    = s_tuser;
        req.pos_x       = s_tdata[7:0];
        req.pos_y       = s_tdata[15:8];
        req.rect_width  = s_tdata[23:16];
        req.rect_height = s_tdata[31:24];
        req.pixel_on    = s_tdata[32];
        req.first_page  = s_tdata[40:33];
        req.last_page   = s_tdata[48:41];
        req.read_page   = s_tdata[51:49];
        req.read_column = s_tdata[58:52];
    end

    pdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdf_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .cmd         (cmd),
        .stat        (stat),
        .pushed_mask (pushed_mask),
        .any_pushed  (any_pushed),
        .read_data   (read_data)
    );

    assign m_tdata = {7'b0, read_data, any_pushed, pushed_mask};

    // one request in flight: ready drops after an acceptance
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // flag agrees with the mask
    `ASSERT_SAME(a_any_matches, aclk, aresetn, m_tvalid, m_tdata[8] == (|m_tdata[7:0]))
    // a result is either a compare mask or read data, never both
    `ASSERT_SAME(a_one_kind, aclk, aresetn, m_tvalid, m_tdata[7:0] == 8'h00 || m_tdata[16:9] == 8'h00)
    // controller never writes the frame store from two sources at once
    `ASSERT_SAME(a_one_writer, aclk, aresetn, cmd.fill_wr || cmd.rmw_wr, !(cmd.fill_wr && cmd.rmw_wr) && !cmd.cmp_rd)

endmodule

`default_nettype wire

// ===== design/pdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdf_ctrl
// request sequencer: clear pass, draw/compare sweeps and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [2:0]           req_type,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    input  pdf_pkg::dp_stat_t    stat,
    output pdf_pkg::dp_cmd_t     cmd
);
    import pdf_pkg::*;

    ctrl_state_t state_reg, state_next;
    res_sel_t    sel_reg, sel_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sel_reg     <= RES_ZERO;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.res_sel  = sel_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                cmd.fill_wr   = 1'b1;
                cmd.fill_zero = 1'b1;
                if (stat.last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    sel_next   = RES_ZERO;
                    state_next = ST_DONE;
                    unique case (req_type)
                        REQ_PIXEL, REQ_RECT: begin
                            if (!stat.rect_empty) begin
                                state_next = ST_RECT_RD;
                            end
                        end
                        REQ_FILL: state_next = ST_FILL;
                        REQ_CMP: begin
                            if (!stat.range_bad) begin
                                sel_next   = RES_MASK;
                                state_next = ST_CMP;
                            end
                        end
                        REQ_INVAL: cmd.clr_valid = 1'b1;
                        REQ_READ: begin
                            sel_next   = RES_READ;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                cmd.fill_wr = 1'b1;
                if (stat.last) begin
                    state_next = ST_DONE;
                end
            end
            ST_RECT_RD: state_next = ST_RECT_WR;
            ST_RECT_WR: begin
                cmd.rmw_wr = 1'b1;
                state_next = stat.last ? ST_DONE : ST_RECT_RD;
            end
            ST_CMP: begin
                cmd.cmp_rd = 1'b1;
                if (stat.last) begin
                    state_next = ST_CMP_TAIL;
                end
            end
            ST_CMP_TAIL: begin
                // last shadow write lands this cycle
                cmd.set_valid = 1'b1;
                state_next    = ST_DONE;
            end
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/pdf_dp.sv =====
// ----------------------------------------------------------------------------
// pdf_dp
// frame store, shadow store, sweep counters and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_dp (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  pdf_pkg::req_fields_t req,
    input  pdf_pkg::dp_cmd_t     cmd,
    output pdf_pkg::dp_stat_t    stat,
    output logic [7:0]           pushed_mask,
    output logic                 any_pushed,
    output logic [7:0]           read_data
);
    import pdf_pkg::*;

    logic [7:0] frame_mem  [STORE_BYTES];
    logic [7:0] shadow_mem [STORE_BYTES];
    logic [7:0] frame_q_reg, shadow_q_reg;

    // sweep position and bounds
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [PAGE_W-1:0] page_hi_reg, page_hi_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  col_lo_reg, col_lo_next;
    logic [COL_W-1:0]  col_hi_reg, col_hi_next;

    logic              shadow_valid_reg, shadow_valid_next;
    logic              cmp_pend_reg;
    logic [ADDR_W-1:0] cmp_addr_reg;
    logic [PAGE_W-1:0] cmp_page_reg;
    logic [PAGES-1:0]  mask_reg, mask_next;

    logic [8:0] y_lo_reg, y_end_reg;
    logic       on_reg, force_reg, read_bad_reg;
    logic [7:0] res_mask_reg, res_data_reg;
    logic       res_any_reg;

    // request decode
    logic       is_pixel;
    logic [8:0] x9, y9, x_end, y_end, x_end_c, y_end_c;
    logic [ADDR_W-1:0] cur_addr;
    logic       advance;
    logic [7:0] row_mask, fill_byte, rmw_byte;
    logic       frame_we;
    logic [7:0] frame_wdata;

    always_comb begin
        is_pixel = (req.req_type == REQ_PIXEL);
        x9       = {1'b0, req.pos_x};
        y9       = {1'b0, req.pos_y};
        x_end    = x9 + {1'b0, (is_pixel ? 8'd1 : req.rect_width)};
        y_end    = y9 + {1'b0, (is_pixel ? 8'd1 : req.rect_height)};
        x_end_c  = (x_end > 9'(COLUMNS)) ? 9'(COLUMNS) : x_end;
        y_end_c  = (y_end > 9'(ROWS)) ? 9'(ROWS) : y_end;

        stat.rect_empty = (x9 >= x_end_c) || (y9 >= y_end_c);
        stat.range_bad  = (req.first_page > req.last_page) || (int'(req.last_page) >= PAGES);
        stat.last       = (page_reg == page_hi_reg) && (col_reg == col_hi_reg);
    end

    assign cur_addr = ADDR_W'(int'(page_reg) * COLUMNS + int'(col_reg));
    assign advance  = cmd.fill_wr || cmd.rmw_wr || cmd.cmp_rd;

    // bits of the current page that fall inside the rectangle rows
    always_comb begin
        logic [8:0] row;
        for (int b = 0; b < 8; b++) begin
            row         = (9'(page_reg) << 3) | 9'(b);
            row_mask[b] = (row >= y_lo_reg) && (row < y_end_reg);
        end
    end

    assign fill_byte   = (cmd.fill_zero || !on_reg) ? BYTE_DARK : BYTE_LIT;
    assign rmw_byte    = (frame_q_reg & ~row_mask) | (on_reg ? row_mask : BYTE_DARK);
    assign frame_we    = cmd.fill_wr || cmd.rmw_wr;
    assign frame_wdata = cmd.fill_wr ? fill_byte : rmw_byte;

    always_comb begin
        page_next         = page_reg;
        page_hi_next      = page_hi_reg;
        col_next          = col_reg;
        col_lo_next       = col_lo_reg;
        col_hi_next       = col_hi_reg;
        shadow_valid_next = shadow_valid_reg;
        mask_next         = mask_reg;

        if (cmd.load) begin
            mask_next = '0;
            priority case (req.req_type)
                REQ_PIXEL, REQ_RECT: begin
                    page_next    = PAGE_W'(req.pos_y >> 3);
                    page_hi_next = PAGE_W'((y_end_c - 9'd1) >> 3);
                    col_next     = COL_W'(req.pos_x);
                    col_lo_next  = COL_W'(req.pos_x);
                    col_hi_next  = COL_W'(x_end_c - 9'd1);
                end
                REQ_CMP: begin
                    page_next    = shadow_valid_reg ? PAGE_W'(req.first_page) : '0;
                    page_hi_next = shadow_valid_reg ? PAGE_W'(req.last_page)
                                                    : PAGE_W'(PAGES - 1);
                    col_next     = '0;
                    col_lo_next  = '0;
                    col_hi_next  = COL_W'(COLUMNS - 1);
                end
                REQ_READ: begin
                    page_next = PAGE_W'(req.read_page);
                    col_next  = COL_W'(req.read_column);
                end
                default: begin
                    page_next    = '0;
                    page_hi_next = PAGE_W'(PAGES - 1);
                    col_next     = '0;
                    col_lo_next  = '0;
                    col_hi_next  = COL_W'(COLUMNS - 1);
                end
            endcase
        end else if (advance) begin
            if (col_reg == col_hi_reg) begin
                col_next  = col_lo_reg;
                page_next = page_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        if (cmp_pend_reg && (force_reg || frame_q_reg != shadow_q_reg)) begin
            mask_next[cmp_page_reg] = 1'b1;
        end

        if (cmd.clr_valid) begin
            shadow_valid_next = 1'b0;
        end else if (cmd.set_valid) begin
            shadow_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg         <= '0;
            page_hi_reg      <= PAGE_W'(PAGES - 1);
            col_reg          <= '0;
            col_lo_reg       <= '0;
            col_hi_reg       <= COL_W'(COLUMNS - 1);
            shadow_valid_reg <= 1'b0;
            cmp_pend_reg     <= 1'b0;
        end else begin
            page_reg         <= page_next;
            page_hi_reg      <= page_hi_next;
            col_reg          <= col_next;
            col_lo_reg       <= col_lo_next;
            col_hi_reg       <= col_hi_next;
            shadow_valid_reg <= shadow_valid_next;
            cmp_pend_reg     <= cmd.cmp_rd;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg     <= mask_next;
        cmp_addr_reg <= cur_addr;
        cmp_page_reg <= page_reg;
        if (cmd.load) begin
            y_lo_reg     <= y9;
            y_end_reg    <= y_end_c;
            on_reg       <= req.pixel_on;
            force_reg    <= !shadow_valid_reg;
            read_bad_reg <= (int'(req.read_page) >= PAGES) || (int'(req.read_column) >= COLUMNS);
        end
        if (cmd.finish) begin
            res_mask_reg <= (cmd.res_sel == RES_MASK) ? 8'(mask_reg) : 8'h00;
            res_any_reg  <= (cmd.res_sel == RES_MASK) && (|mask_reg);
            res_data_reg <= (cmd.res_sel == RES_READ && !read_bad_reg) ? frame_q_reg : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[cur_addr] <= frame_wdata;
        end
        frame_q_reg <= frame_mem[cur_addr];
    end

    // compare copies every swept byte, so equal bytes rewrite the same value
    always_ff @(posedge aclk) begin
        if (cmp_pend_reg) begin
            shadow_mem[cmp_addr_reg] <= frame_q_reg;
        end
        shadow_q_reg <= shadow_mem[cur_addr];
    end

    assign pushed_mask = res_mask_reg;
    assign any_pushed  = res_any_reg;
    assign read_data   = res_data_reg;

endmodule

`default_nettype wire
